>>> sv/icsc_pkg.sv
package icsc_pkg;

  // scanner state codes
  localparam logic [3:0] ST_SCAN = 4'd0;
  localparam logic [3:0] ST_OCT1 = 4'd1;
  localparam logic [3:0] ST_DOT1 = 4'd2;
  localparam logic [3:0] ST_OCT2 = 4'd3;
  localparam logic [3:0] ST_DOT2 = 4'd4;
  localparam logic [3:0] ST_OCT3 = 4'd5;
  localparam logic [3:0] ST_DOT3 = 4'd6;
  localparam logic [3:0] ST_OCT4 = 4'd7;
  localparam logic [3:0] ST_PFX1 = 4'd8;
  localparam logic [3:0] ST_PFX2 = 4'd9;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [6:0] DEFAULT_PREFIX = 7'd32;
  localparam logic [7:0] INDEX_MAX      = 8'hFF;

  typedef struct packed {
    logic [3:0]  state;
    logic [31:0] addr;
    logic [7:0]  octet;
    logic [6:0]  prefix;
  } scan_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic [6:0]  prefix_len;
  } emit_t;

  localparam scan_t SCAN_RESET = '{
    state:  ST_SCAN,
    addr:   32'd0,
    octet:  8'd0,
    prefix: DEFAULT_PREFIX
  };

endpackage

>>> sv/icsc_step.sv
module icsc_step (
  input  icsc_pkg::scan_t cur_i,
  input  logic [7:0]      text_byte_i,
  input  logic            line_end_i,
  output icsc_pkg::scan_t nxt_o,
  output icsc_pkg::emit_t emit_o
);
  import icsc_pkg::*;

  logic       digit;
  logic [3:0] d;
  logic [7:0] oct_acc;
  logic [6:0] pfx_acc;
  logic [31:0] fold_addr;
  scan_t      scan_c;
  logic       done;
  logic       tail_fold;
  logic       tail_pfx;

  assign digit     = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);
  assign d         = text_byte_i[3:0];
  // decimal accumulate, wraps mod 256 / 128
  assign oct_acc   = 8'(cur_i.octet * 8'd10 + {4'd0, d});
  assign pfx_acc   = 7'(cur_i.prefix * 7'd10 + {3'd0, d});
  assign fold_addr = {cur_i.addr[23:0], cur_i.octet};

  always_comb begin
    scan_c = cur_i;
    done   = 1'b0;
    case (cur_i.state)
      ST_SCAN: begin
        if (digit) begin
          scan_c.addr  = 32'd0;
          scan_c.octet = {4'd0, d};
          scan_c.state = ST_OCT1;
        end
      end
      ST_OCT1, ST_OCT2, ST_OCT3: begin
        if (digit) begin
          scan_c.octet = oct_acc;
        end else if (text_byte_i == CH_DOT) begin
          scan_c.state = 4'(cur_i.state + 4'd1);
        end else begin
          scan_c.state = ST_SCAN;
        end
      end
      ST_DOT1: begin
        if (digit) begin
          scan_c.addr  = {24'd0, cur_i.octet};
          scan_c.octet = {4'd0, d};
          scan_c.state = ST_OCT2;
        end else begin
          scan_c.state = ST_SCAN;
        end
      end
      ST_DOT2, ST_DOT3: begin
        if (digit) begin
          scan_c.addr  = fold_addr;
          scan_c.octet = {4'd0, d};
          scan_c.state = 4'(cur_i.state + 4'd1);
        end else begin
          scan_c.state = ST_SCAN;
        end
      end
      ST_OCT4: begin
        if (digit) begin
          scan_c.octet = oct_acc;
        end else if (text_byte_i == CH_SLASH) begin
          scan_c.addr  = fold_addr;
          scan_c.octet = 8'd0;
          scan_c.state = ST_PFX1;
        end else begin
          scan_c.addr  = fold_addr;
          scan_c.octet = 8'd0;
          done         = 1'b1;
        end
      end
      ST_PFX1: begin
        if (digit) begin
          scan_c.prefix = {3'd0, d};
          scan_c.state  = ST_PFX2;
        end else begin
          scan_c.prefix = DEFAULT_PREFIX;
          done          = 1'b1;
        end
      end
      ST_PFX2: begin
        if (digit) begin
          scan_c.prefix = pfx_acc;
        end
        done = 1'b1;
      end
      default: begin
        scan_c.state = ST_SCAN;
      end
    endcase
  end

  // line end flushes a pending complete address
  assign tail_fold = line_end_i && !done && (scan_c.state == ST_OCT4);
  assign tail_pfx  = line_end_i && !done &&
                     ((scan_c.state == ST_PFX1) || (scan_c.state == ST_PFX2));

  assign emit_o.valid      = done || tail_fold || tail_pfx;
  assign emit_o.address    = tail_fold ? {scan_c.addr[23:0], scan_c.octet} : scan_c.addr;
  assign emit_o.prefix_len = scan_c.prefix;

  assign nxt_o = (done || line_end_i) ? SCAN_RESET : scan_c;

endmodule

>>> sv/ipv4_cidr_text_scanner_unit.sv
// IPv4 dotted-quad / CIDR scanner.
//
// Input channel: one text byte per word (in_text_byte) plus in_line_end,
// which marks the last byte of a line. A word is taken on a clock edge with
// in_valid high and in_stall low.
// Output channel: one word per address found: out_address (first octet in
// bits 31:24), out_prefix_len (32 when no prefix digits), and
// out_index_in_line (count of addresses so far in the line, saturating at
// 255). Taken on an edge with out_valid high and out_stall low.
//
// Result: the word and out_valid are registered when the byte that ends
// the address is taken (terminator byte, second prefix digit, or the line-end byte).
// Throughput: one byte per cycle while in_stall is low. The scanner state
// updates through a short decode/accumulate path and feeds a single output register.
//
// Stall: in_stall is raised only while the output register holds a word and
// out_stall is high; the held word does not change until it is taken.
// Reset (rst_n low, synchronous): scanner returns to searching for a first
// digit, the line's address count clears and out_valid drops.
module ipv4_cidr_text_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_line_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_address,
  output logic [6:0]  out_prefix_len,
  output logic [7:0]  out_index_in_line
);
  import icsc_pkg::*;

  scan_t       scan_r;
  scan_t       scan_nxt;
  emit_t       emit;
  logic [7:0]  found_r;
  logic [7:0]  found_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_address_r;
  logic [6:0]  out_prefix_r;
  logic [7:0]  out_index_r;
  logic        in_take;

  // output register can be refilled in the same cycle it is drained
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  icsc_step u_step (
    .cur_i       (scan_r),
    .text_byte_i (in_text_byte),
    .line_end_i  (in_line_end),
    .nxt_o       (scan_nxt),
    .emit_o      (emit)
  );

  // per-line address count; cleared after the line's last byte
  always_comb begin
    found_nxt = found_r;
    if (emit.valid && (found_r != INDEX_MAX)) begin
      found_nxt = 8'(found_r + 8'd1);
    end
    if (in_line_end) begin
      found_nxt = 8'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = emit.valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= SCAN_RESET;
      found_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        scan_r  <= scan_nxt;
        found_r <= found_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_take && emit.valid) begin
      out_address_r <= emit.address;
      out_prefix_r  <= emit.prefix_len;
      out_index_r   <= found_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_address       = out_address_r;
  assign out_prefix_len    = out_prefix_r;
  assign out_index_in_line = out_index_r;

endmodule

>>> sv/icsc_checker.sv
module icsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_address,
  input logic [6:0]  out_prefix_len,
  input logic [7:0]  out_index_in_line
);

  // held word stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_address) &&
      $stable(out_prefix_len) && $stable(out_index_in_line))
    else $error("output word changed while stalled");

  // input back-pressure only comes from a blocked output word
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  // a new result needs an accepted byte on the cycle before
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an accepted byte");

  // prefix is at most two decimal digits
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_prefix_len <= 7'd99)
    else $error("prefix length out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ipv4_cidr_text_scanner_unit icsc_checker u_icsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_address       (out_address),
  .out_prefix_len    (out_prefix_len),
  .out_index_in_line (out_index_in_line)
);

>>> verif/ipv4_cidr_text_scanner_unit_tb.sv
`timescale 1ns / 1ps

module ipv4_cidr_text_scanner_unit_tb;
  import icsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 300;

  typedef logic [7:0] text_bytes_t [$];

  typedef struct {
    logic [7:0] text;
    logic       last;
  } text_word_t;

  typedef struct {
    logic [31:0] address;
    logic [6:0]  prefix_len;
    logic [7:0]  index_in_line;
  } cidr_hit_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_text_byte;
  logic        in_line_end;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_address;
  logic [6:0]  out_prefix_len;
  logic [7:0]  out_index_in_line;

  ipv4_cidr_text_scanner_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .in_line_end       (in_line_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_address       (out_address),
    .out_prefix_len    (out_prefix_len),
    .out_index_in_line (out_index_in_line)
  );

  // text words waiting to be sent, and addresses the scanner still owes us
  text_word_t text_q[$];
  cidr_hit_t  hit_due_q[$];

  int  idle_pct;
  int  stall_pct;
  int  words_queued;
  int  mismatches;
  int  quiet_cycles;
  logic in_taken;

  // scanner shadow state
  logic [3:0]  sc_state;
  logic [31:0] sc_addr;
  logic [7:0]  sc_octet;
  logic [6:0]  sc_prefix;
  logic [7:0]  sc_hits;

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_scan();
    sc_state  = ST_SCAN;
    sc_addr   = 32'd0;
    sc_octet  = 8'd0;
    sc_prefix = DEFAULT_PREFIX;
  endfunction

  function automatic void record_hit();
    hit_due_q.push_back('{address: sc_addr, prefix_len: sc_prefix,
                          index_in_line: sc_hits});
    if (sc_hits != INDEX_MAX)
      sc_hits = sc_hits + 8'd1;
  endfunction

  // Advance the shadow scanner by one accepted text word.
  function automatic void scan_text_byte(input logic [7:0] b, input logic last);
    logic       digit;
    logic [7:0] d;
    logic       done;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    d     = b - CH_ZERO;
    done  = 1'b0;
    case (sc_state)
      ST_SCAN: begin
        if (digit) begin
          sc_addr  = 32'd0;
          sc_octet = d;
          sc_state = ST_OCT1;
        end
      end
      ST_OCT1, ST_OCT2, ST_OCT3: begin
        if (digit)
          sc_octet = sc_octet * 8'd10 + d;   // wraps mod 256
        else if (b == CH_DOT)
          sc_state = sc_state + 4'd1;
        else
          sc_state = ST_SCAN;
      end
      ST_DOT1: begin
        if (digit) begin
          sc_addr  = {24'd0, sc_octet};
          sc_octet = d;
          sc_state = ST_OCT2;
        end else begin
          sc_state = ST_SCAN;
        end
      end
      ST_DOT2, ST_DOT3: begin
        if (digit) begin
          sc_addr  = {sc_addr[23:0], sc_octet};
          sc_octet = d;
          sc_state = sc_state + 4'd1;
        end else begin
          sc_state = ST_SCAN;
        end
      end
      ST_OCT4: begin
        if (digit) begin
          sc_octet = sc_octet * 8'd10 + d;
        end else if (b == CH_SLASH) begin
          sc_addr  = {sc_addr[23:0], sc_octet};
          sc_octet = 8'd0;
          sc_state = ST_PFX1;
        end else begin
          sc_addr  = {sc_addr[23:0], sc_octet};
          sc_octet = 8'd0;
          done     = 1'b1;
        end
      end
      ST_PFX1: begin
        if (digit) begin
          sc_prefix = d[6:0];
          sc_state  = ST_PFX2;
        end else begin
          sc_prefix = DEFAULT_PREFIX;
          done      = 1'b1;
        end
      end
      ST_PFX2: begin
        if (digit)
          sc_prefix = sc_prefix * 7'd10 + d[6:0];
        done = 1'b1;
      end
      default: sc_state = ST_SCAN;
    endcase

    if (done) begin
      record_hit();
      clear_scan();
    end

    // line end flushes a complete pending address, drops anything shorter
    if (last) begin
      if (!done) begin
        if (sc_state == ST_OCT4) begin
          sc_addr  = {sc_addr[23:0], sc_octet};
          sc_octet = 8'd0;
          record_hit();
        end else if (sc_state == ST_PFX1 || sc_state == ST_PFX2) begin
          record_hit();
        end
      end
      clear_scan();
      sc_hits = 8'd0;
    end
  endfunction

  function automatic text_bytes_t str_bytes(input string s);
    text_bytes_t bq;
    bq = {};
    for (int i = 0; i < s.len(); i++)
      bq.push_back(s[i]);
    return bq;
  endfunction

  // Queue a byte run; end_line marks its final byte as the last of the line.
  task automatic queue_line(input text_bytes_t bq, input bit end_line);
    for (int i = 0; i < bq.size(); i++)
      text_q.push_back('{text: bq[i], last: end_line && (i == bq.size() - 1)});
    words_queued += bq.size();
  endtask

  // One random line: mostly well-formed addresses, some broken ones, some noise.
  task automatic random_line();
    text_bytes_t bq;
    int ntok;
    int kind;
    int ndig;
    int start;
    int cut;
    logic [7:0] sep;
    bq = {};
    ntok = $urandom_range(1, 5);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        repeat ($urandom_range(1, 6)) bq.push_back(8'($urandom_range(255)));
      end else begin
        start = bq.size();
        for (int o = 0; o < 4; o++) begin
          if (o > 0)
            bq.push_back(CH_DOT);
          ndig = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
          repeat (ndig) bq.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(1) == 1) begin
          bq.push_back(CH_SLASH);
          repeat ($urandom_range(2)) bq.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
        if (kind < 35) begin
          // broken: cut short, or a stray dot somewhere inside
          cut = start + $urandom_range(1, bq.size() - start - 1);
          if ($urandom_range(1) == 1) begin
            while (bq.size() > cut)
              void'(bq.pop_back());
          end else begin
            bq.insert(cut, CH_DOT);
          end
        end
      end
      // separator; the final token often runs straight into line end
      if (t < ntok - 1 || $urandom_range(2) == 0) begin
        if ($urandom_range(1) == 1) begin
          sep = 8'h20;
        end else begin
          do
            sep = 8'($urandom_range(255));
          while ((sep >= CH_ZERO && sep <= CH_NINE) || sep == CH_SLASH);
        end
        bq.push_back(sep);
      end
    end
    queue_line(bq, 1'b1);
  endtask

  // Driver: a new word goes out only once the held one has been taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (text_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid     <= 1'b1;
          in_text_byte <= text_q[0].text;
          in_line_end  <= text_q[0].last;
          void'(text_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Monitor: check the result word first, then fold in the accepted text word
  // (its own result cannot show before the next edge).
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hit_due_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: addr %h prefix %0d index %0d",
                     out_address, out_prefix_len, out_index_in_line);
          mismatches++;
        end else begin
          if (out_address !== hit_due_q[0].address ||
              out_prefix_len !== hit_due_q[0].prefix_len ||
              out_index_in_line !== hit_due_q[0].index_in_line) begin
            if (mismatches < 10)
              $display({"mismatch: exp addr %h prefix %0d index %0d, ",
                        "got addr %h prefix %0d index %0d"},
                       hit_due_q[0].address, hit_due_q[0].prefix_len,
                       hit_due_q[0].index_in_line,
                       out_address, out_prefix_len, out_index_in_line);
            mismatches++;
          end
          void'(hit_due_q.pop_front());
        end
      end
      if (in_valid && !in_stall)
        scan_text_byte(in_text_byte, in_line_end);
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    text_bytes_t bq;
    int phase_start;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = 8'd0;
    in_line_end  = 1'b0;
    out_stall    = 1'b0;
    in_taken     = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    words_queued = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    clear_scan();
    sc_hits = 8'd0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase

      if (ph == 0) begin
        // top octet, long fourth octet, two-digit prefix ending the address
        queue_line(str_bytes("255.0.0.9999/99"), 1'b0);
        bq = {8'h00};
        queue_line(bq, 1'b0);
        // dot before a digit breaks; then zero fourth octet flushed at line end
        queue_line(str_bytes("1..0.0.0.0"), 1'b1);
        // one-digit prefix closed by an 0xFF terminator, then a dropped partial
        bq = str_bytes("6.6.6.6/5");
        bq.push_back(8'hFF);
        bq = {bq, str_bytes("1.2.3")};
        queue_line(bq, 1'b1);
      end

      phase_start = words_queued;
      while (words_queued - phase_start < RANDOM_PER_PHASE)
        random_line();

      // drain this phase's words before moving on
      while (text_q.size() != 0 || in_valid)
        @(posedge clk);
    end

    while (hit_due_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && hit_due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
sv/icsc_pkg.sv
sv/icsc_step.sv
sv/ipv4_cidr_text_scanner_unit.sv
sv/icsc_checker.sv
verif/ipv4_cidr_text_scanner_unit_tb.sv
